>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sleep timeout queue.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/sto_pkg.sv
// Package of the sleep timeout queue: sizes, codes and the cell types.
// Depends on nothing.
`default_nettype none
package sto_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdBits     = 8;
  localparam int unsigned MaxWakes   = 16;

  localparam int unsigned IdW   = (IdBits < 8) ? IdBits : 8;
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  localparam int unsigned WakeW = $clog2(MaxWakes + 1);
  localparam int unsigned TickW = 63;
  localparam int unsigned RemW  = 32;

  typedef enum logic [0:0] {
    FUNC_SLEEP = 1'b0,
    FUNC_TICK  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_WOKEN    = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_INSERT,
    OP_DEC,
    OP_POP
  } cell_op_e;

  typedef enum logic [0:0] {
    S_IDLE,
    S_WAKE
  } state_e;

  // One queue entry as held in a cell and handed to a neighbour.
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [IdW-1:0]  id;
  } entry_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cell_op_e        op;
    logic [RemW-1:0] ticks;
    logic [IdW-1:0]  id;
  } cell_cmd_t;

endpackage
`default_nettype wire

>>> rtl/sto_in_if.sv
// Request channel of the sleep timeout queue: valid, ready and one request word.
// Depends on nothing.
`default_nettype none
interface sto_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [7:0]         thread_id;
  logic signed [31:0] nap_ticks;

  modport source (output valid, func, thread_id, nap_ticks, input ready);
  modport sink   (input valid, func, thread_id, nap_ticks, output ready);
endinterface
`default_nettype wire

>>> rtl/sto_out_if.sv
// Result channel of the sleep timeout queue: valid, ready and one result word.
// Depends on nothing.
`default_nettype none
interface sto_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  woken_id;
  logic [62:0] tick_count;
  logic        last;

  modport source (output valid, status, woken_id, tick_count, last, input ready);
  modport sink   (input valid, status, woken_id, tick_count, last, output ready);
endinterface
`default_nettype wire

>>> rtl/sto_cell.sv
// One cell of the sorted queue row: holds one entry, inserts, counts down, shifts.
// Depends on sto_pkg.
`default_nettype none
module sto_cell import sto_pkg::*; (
  input  wire logic      clk_i,
  input  wire cell_cmd_t cmd_i,
  input  wire logic      occ_i,       // entry lies below the fill count
  input  wire entry_t    left_i,      // entry of the neighbour towards the front
  input  wire logic      left_less_i, // neighbour keeps its place on insert
  input  wire entry_t    right_i,     // entry of the neighbour towards the back
  output entry_t         entry_o,
  output logic           less_o
);

  entry_t ent_q, ent_d;

  // Held entry is strictly smaller than the new count: it stays in front
  assign less_o  = occ_i && (ent_q.rem < cmd_i.ticks);
  assign entry_o = ent_q;

  always_comb begin
    ent_d = ent_q;
    unique case (cmd_i.op)
      OP_INSERT: begin
        if (!less_o) begin
          if (left_less_i) begin
            ent_d.rem = cmd_i.ticks;
            ent_d.id  = cmd_i.id;
          end else begin
            ent_d = left_i;
          end
        end
      end
      OP_DEC: begin
        if (ent_q.rem != '0) ent_d.rem = ent_q.rem - RemW'(1);
      end
      OP_POP:  ent_d = right_i;
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule
`default_nettype wire

>>> rtl/sleep_timeout_queue.sv
// Top level of the sleep timeout queue: a row of sto_cell and its sequencer.
// Depends on sto_pkg, sto_in_if, sto_out_if, sto_cell and assert_macros.svh.
//
//   channel | dir | word                                  | accepted when
//   req_i   | in  | func, thread_id, nap_ticks            | valid && ready
//   rsp_o   | out | status, woken_id, tick_count, last    | valid && ready
//
// A sleep request has every cell decide in parallel whether to
// keep, take the new entry or take its front neighbour's entry.
// A tick counts down every cell, then gives one result per woken thread
// (at least one: the none-woken result); the row shifts one place a cycle unless stalled.
// Reset clears the fill count, tick counter and sequencer; cell contents are not cleared.
// A stalled result holds the output register; no request is taken meanwhile.
`default_nettype none
`include "assert_macros.svh"
module sleep_timeout_queue import sto_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sto_in_if.sink    req_i,
  sto_out_if.source rsp_o
);

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [WakeW-1:0]  wakes_q, wakes_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic              rsp_valid_q;
  status_e           rsp_status_q, ld_status;
  logic [IdW-1:0]    rsp_id_q, ld_id;
  logic [TickW-1:0]  rsp_tick_q;
  logic              rsp_last_q, ld_last;
  logic              load;
  logic              out_free;
  logic              front_exp;
  logic [RemW-1:0]   new_ticks;
  cell_cmd_t         cmd;

  entry_t            ent  [QueueDepth];
  logic              less [QueueDepth];

  // Clamp negative counts to zero
  assign new_ticks = req_i.nap_ticks[31] ? '0 : RemW'(req_i.nap_ticks);

  // Row of cells, each wired to both neighbours
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_less, occ;

    assign occ = CntW'(i) < count_q;
    if (i == 0) begin : g_front
      assign left_ent  = ent[0];
      assign left_less = 1'b1;
    end else begin : g_mid
      assign left_ent  = ent[i-1];
      assign left_less = less[i-1];
    end
    if (i == QueueDepth - 1) begin : g_back
      assign right_ent = ent[i];
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    sto_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occ_i       (occ),
      .left_i      (left_ent),
      .left_less_i (left_less),
      .right_i     (right_ent),
      .entry_o     (ent[i]),
      .less_o      (less[i])
    );
  end

  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign front_exp = (count_q != '0) && (ent[0].rem == '0) && (wakes_q < WakeW'(MaxWakes));

  // Sequencer: next state, cell command and result word
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    wakes_d     = wakes_q;
    tick_d      = tick_q;
    cmd.op      = OP_NOP;
    cmd.ticks   = new_ticks;
    cmd.id      = req_i.thread_id[IdW-1:0];
    load        = 1'b0;
    ld_status   = ST_ACCEPTED;
    ld_id       = req_i.thread_id[IdW-1:0];
    ld_last     = 1'b1;
    req_i.ready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_i.ready = out_free;
        if (req_i.valid && out_free) begin
          if (func_e'(req_i.func) == FUNC_TICK) begin
            cmd.op  = OP_DEC;
            tick_d  = tick_q + TickW'(1);
            wakes_d = '0;
            state_d = S_WAKE;
          end else if (count_q == CntW'(QueueDepth)) begin
            load      = 1'b1;
            ld_status = ST_FULL;
          end else begin
            cmd.op    = OP_INSERT;
            count_d   = count_q + CntW'(1);
            load      = 1'b1;
            ld_status = ST_ACCEPTED;
          end
        end
      end
      S_WAKE: begin
        if (out_free) begin
          load = 1'b1;
          if (front_exp) begin
            cmd.op    = OP_POP;
            count_d   = count_q - CntW'(1);
            wakes_d   = wakes_q + WakeW'(1);
            ld_status = ST_WOKEN;
            ld_id     = ent[0].id;
            ld_last   = !((count_q > CntW'(1)) && (ent[1].rem == '0) &&
                          (wakes_q < WakeW'(MaxWakes - 1)));
            if (ld_last) state_d = S_IDLE;
          end else begin
            ld_status = ST_NONE;
            ld_id     = '0;
            state_d   = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      wakes_q     <= '0;
      tick_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      wakes_q <= wakes_d;
      tick_q  <= tick_d;
      if (load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Result word, held while the sink stalls
  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_status_q <= ld_status;
      rsp_id_q     <= ld_id;
      rsp_tick_q   <= tick_q;
      rsp_last_q   <= ld_last;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.woken_id   = 8'(rsp_id_q);
  assign rsp_o.tick_count = rsp_tick_q;
  assign rsp_o.last       = rsp_last_q;

  `ASSERT_NEVER(a_count_in_range, clk_i, rst_ni, count_q > CntW'(QueueDepth), "fill count overflow")
  `ASSERT_PROP(a_wake_pops, clk_i, rst_ni, (load && ld_status == ST_WOKEN) |=> (count_q == $past(count_q) - CntW'(1)), "wake without pop")
  `ASSERT_PROP(a_tick_enters_wake, clk_i, rst_ni, (state_q == S_IDLE && req_i.valid && req_i.ready && req_i.func) |=> (state_q == S_WAKE), "tick not followed by wake pass")
  `ASSERT_PROP(a_none_is_last, clk_i, rst_ni, (load && ld_status == ST_NONE) |-> (wakes_q == '0 && ld_last), "none-woken result out of place")

endmodule
`default_nettype wire
